@@ hdl/mbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus coil slave package
// Shared constants, state and select encodings, the controller/datapath
// command and status groups, and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mbcs_pkg;

    // Frame and coil geometry.
    localparam int COIL_COUNT  = 18;
    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    // Function codes and fixed reply bytes.
    localparam logic [7:0] FUNC_READ_COILS  = 8'h01;
    localparam logic [7:0] FUNC_WRITE_COIL  = 8'h05;
    localparam logic [7:0] READ_BYTE_COUNT  = 8'h04;
    localparam logic [7:0] COIL_ON_VALUE    = 8'hFF;
    localparam logic [7:0] PAD_BYTE         = 8'h00;

    // Frame byte positions.
    localparam logic [POS_W-1:0] POS_STATION  = 3'd0;
    localparam logic [POS_W-1:0] POS_FUNCTION = 3'd1;
    localparam logic [POS_W-1:0] POS_ADDR_LO  = 3'd3;
    localparam logic [POS_W-1:0] POS_DATA_HI  = 3'd4;
    localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd6;
    localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd7;

    // Sequencer counts: bytes covered by the check and reply payload lengths.
    localparam logic [3:0] CHECK_LAST = 4'd5;
    localparam logic [3:0] READ_LEN   = 4'd7;
    localparam logic [3:0] WRITE_LEN  = 4'd6;

    // CRC-16/MODBUS.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_VERIFY,
        ST_SEND_READ,
        ST_SEND_WRITE
    } state_t;

    typedef enum logic [1:0] {
        SEL_FRAME,
        SEL_READ_MSG,
        SEL_CRC_LO,
        SEL_CRC_HI
    } byte_sel_t;

    typedef struct packed {
        logic      store_byte;
        logic      crc_init;
        logic      crc_feed;
        logic      coil_update;
        logic      out_load;
        logic      out_last;
        byte_sel_t sel;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic crc_ok;
        logic func_read;
        logic func_write;
        logic out_free;
    } status_t;

    // One byte of the reflected CRC, eight shift steps.
    function automatic logic [15:0] crc_update(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/mbcs_if.sv @@
// ----------------------------------------------------------------------------
// Modbus coil slave channel interfaces
// Valid/ready channels for received bytes, reply bytes and the status
// register write.
// ----------------------------------------------------------------------------
interface mbcs_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbcs_tx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [17:0] coil_states;

    modport source (output valid, output tx_byte, output last_byte, output coil_states,
                    input ready);
    modport sink   (input valid, input tx_byte, input last_byte, input coil_states,
                    output ready);
endinterface

interface mbcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] extra_status_bits;

    modport source (output valid, output extra_status_bits, input ready);
    modport sink   (input valid, input extra_status_bits, output ready);
endinterface

@@ hdl/mbcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Modbus coil slave controller
// Sequences byte collection, the CRC check pass, the dispatch on function
// code and the byte-by-byte reply.
// ----------------------------------------------------------------------------
module mbcs_ctrl
    import mbcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rx_valid,
    output logic    rx_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] reply_len;

    // Payload length of the reply being sent.
    assign reply_len = (state_reg == ST_SEND_READ) ? READ_LEN : WRITE_LEN;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid && status.frame_end)
                begin
                    state_next = ST_CHECK;
                    cnt_next   = '0;
                end
            end
            ST_CHECK:
            begin
                if (cnt_reg == CHECK_LAST)
                begin
                    state_next = ST_VERIFY;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_VERIFY:
            begin
                if (status.crc_ok && status.func_read)
                begin
                    state_next = ST_SEND_READ;
                end
                else if (status.crc_ok && status.func_write)
                begin
                    state_next = ST_SEND_WRITE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND_READ, ST_SEND_WRITE:
            begin
                if (status.out_free)
                begin
                    if (cnt_reg == reply_len + 4'd1)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Outputs to the datapath.
    always_comb
    begin
        cmd      = '0;
        cmd.sel  = SEL_FRAME;
        cmd.idx  = cnt_reg;
        rx_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rx_ready       = 1'b1;
                cmd.store_byte = rx_valid;
                cmd.crc_init   = rx_valid && status.frame_end;
            end
            ST_CHECK:
            begin
                cmd.crc_feed = 1'b1;
            end
            ST_VERIFY:
            begin
                cmd.crc_init    = status.crc_ok && (status.func_read || status.func_write);
                cmd.coil_update = status.crc_ok && status.func_write;
            end
            ST_SEND_READ, ST_SEND_WRITE:
            begin
                cmd.out_load = status.out_free;
                if (cnt_reg < reply_len)
                begin
                    cmd.sel      = (state_reg == ST_SEND_READ) ? SEL_READ_MSG : SEL_FRAME;
                    cmd.crc_feed = status.out_free;
                end
                else if (cnt_reg == reply_len)
                begin
                    cmd.sel = SEL_CRC_LO;
                end
                else
                begin
                    cmd.sel      = SEL_CRC_HI;
                    cmd.out_last = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hdl/mbcs_datapath.sv @@
// ----------------------------------------------------------------------------
// Modbus coil slave datapath
// Frame store, byte position, CRC register, coil register, status register
// and the reply output register.
// ----------------------------------------------------------------------------
module mbcs_datapath
    import mbcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [7:0]            rx_byte,
    input  logic                  cfg_valid,
    input  logic [7:0]            cfg_data,
    input  logic                  tx_ready,
    output logic                  tx_valid,
    output logic [7:0]            tx_byte,
    output logic                  last_byte,
    output logic [COIL_COUNT-1:0] coil_states
);

    logic [7:0]            frame_reg [FRAME_BYTES];
    logic [POS_W-1:0]      pos_reg;
    logic [15:0]           crc_reg;
    logic [COIL_COUNT-1:0] coils_reg, coils_next;
    logic [7:0]            extra_reg;
    logic                  tx_valid_reg;
    logic [7:0]            tx_byte_reg;
    logic                  last_reg;
    logic [COIL_COUNT-1:0] tx_coils_reg;
    logic [7:0]            read_byte;
    logic [7:0]            sel_byte;
    logic [7:0]            addr;

    // Frame store, written at the current byte position.
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            frame_reg[pos_reg] <= rx_byte;
        end
    end

    // Byte position wraps after the eighth byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.store_byte)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    // Status byte register, written from the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg <= '0;
        end
        else if (cfg_valid)
        begin
            extra_reg <= cfg_data;
        end
    end

    // Payload bytes of the read-coils reply.
    always_comb
    begin
        case (cmd.idx)
            4'd0:    read_byte = frame_reg[POS_STATION];
            4'd1:    read_byte = frame_reg[POS_FUNCTION];
            4'd2:    read_byte = READ_BYTE_COUNT;
            4'd3:    read_byte = coils_reg[7:0];
            4'd4:    read_byte = coils_reg[15:8];
            4'd5:    read_byte = ~({7'b0, ~coils_reg[16]} | extra_reg);
            default: read_byte = PAD_BYTE;
        endcase
    end

    // Byte selected for the CRC and for the output register.
    always_comb
    begin
        case (cmd.sel)
            SEL_FRAME:    sel_byte = frame_reg[cmd.idx[POS_W-1:0]];
            SEL_READ_MSG: sel_byte = read_byte;
            SEL_CRC_LO:   sel_byte = crc_reg[7:0];
            SEL_CRC_HI:   sel_byte = crc_reg[15:8];
            default:      sel_byte = PAD_BYTE;
        endcase
    end

    // CRC register: one byte per cycle while crc_feed is set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else if (cmd.crc_init)
        begin
            crc_reg <= CRC_INIT;
        end
        else if (cmd.crc_feed)
        begin
            crc_reg <= crc_update(crc_reg, sel_byte);
        end
    end

    // Single coil write from the low address byte; values beyond the last coil change nothing.
    assign addr = frame_reg[POS_ADDR_LO];

    always_comb
    begin
        coils_next = coils_reg;
        for (int i = 0; i < COIL_COUNT; i++)
        begin
            if (addr == 8'(i))
            begin
                coils_next[i] = (frame_reg[POS_DATA_HI] == COIL_ON_VALUE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coils_reg <= '0;
        end
        else if (cmd.coil_update)
        begin
            coils_reg <= coils_next;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            tx_valid_reg <= 1'b1;
        end
        else if (tx_ready)
        begin
            tx_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            tx_byte_reg  <= sel_byte;
            last_reg     <= cmd.out_last;
            tx_coils_reg <= coils_reg;
        end
    end

    // Status towards the controller.
    always_comb
    begin
        status.frame_end  = (pos_reg == POS_CRC_HI);
        status.crc_ok     = (frame_reg[POS_CRC_LO] == crc_reg[7:0]) &&
                            (frame_reg[POS_CRC_HI] == crc_reg[15:8]);
        status.func_read  = (frame_reg[POS_FUNCTION] == FUNC_READ_COILS);
        status.func_write = (frame_reg[POS_FUNCTION] == FUNC_WRITE_COIL);
        status.out_free   = !tx_valid_reg || tx_ready;
    end

    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign last_byte   = last_reg;
    assign coil_states = tx_coils_reg;

endmodule

@@ hdl/modbus_coil_slave_frame_handler.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU coil slave frame handler
// Collects 8-byte requests, checks CRC-16/MODBUS, serves read coils and
// write single coil, and sends the reply one byte per transfer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                              Transfer
//  rx       in         rx_byte[7:0]                         valid & ready
//  tx       out        tx_byte[7:0], last_byte, coil_states valid & ready
//  cfg      in         extra_status_bits[7:0]               valid & ready
//
//  Bytes one to seven of a frame are taken whenever rx offers them.
//  The eighth byte starts a CRC pass over stored bytes zero to five (one
//  stored byte per cycle through the CRC register), a decode step, and then
//  nine (read) or eight (write) reply loads, one per cycle while tx takes them.
//  rx is held off during the check and the reply; it reopens while the last
//  reply byte still waits in the output register. cfg is always ready.
//  Reset clears the byte position, the coils, the status register and tx.
// ----------------------------------------------------------------------------
module modbus_coil_slave_frame_handler
    import mbcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    mbcs_rx_if.sink    rx,
    mbcs_tx_if.source  tx,
    mbcs_cfg_if.sink   cfg
);

    cmd_t    cmd;
    status_t status;

    // Status register writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    // Sequencer.
    mbcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    mbcs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .rx_byte     (rx.rx_byte),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.extra_status_bits),
        .tx_ready    (tx.ready),
        .tx_valid    (tx.valid),
        .tx_byte     (tx.tx_byte),
        .last_byte   (tx.last_byte),
        .coil_states (tx.coil_states)
    );

endmodule

@@ hdl/mbcs_checker.sv @@
// ----------------------------------------------------------------------------
// Modbus coil slave port checker
// Watches the top level's ports for reply ordering and output stability.
// ----------------------------------------------------------------------------
module mbcs_checker
    import mbcs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rx_ready,
    input logic                  tx_valid,
    input logic                  tx_ready,
    input logic [7:0]            tx_byte,
    input logic                  last_byte,
    input logic [COIL_COUNT-1:0] coil_states
);

    // A stalled reply byte holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && !tx_ready) |=>
            (tx_valid && $stable(tx_byte) && $stable(last_byte) && $stable(coil_states)))
    else $error("reply payload changed while stalled");

    // No new request byte is taken while a reply is unfinished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && !last_byte) |-> !rx_ready)
    else $error("receive side open in the middle of a reply");

    // Within one reply the bytes follow without a gap and carry one coil image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && !last_byte) |=>
            (tx_valid && (coil_states == $past(coil_states))))
    else $error("reply interrupted or coil image changed within a reply");

endmodule

bind modbus_coil_slave_frame_handler mbcs_checker u_mbcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_ready    (rx.ready),
    .tx_valid    (tx.valid),
    .tx_ready    (tx.ready),
    .tx_byte     (tx.tx_byte),
    .last_byte   (tx.last_byte),
    .coil_states (tx.coil_states)
);
